>>> hdl/p3su_pkg.sv
// Shared types, register codes and Q8.24 saturating arithmetic for the
// periodic 3D stencil update block. No dependencies.
`default_nettype none
package p3su_pkg;

  localparam int unsigned QW = 32;

  typedef logic signed [QW-1:0] q_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ADVECT = 3'd0,
    REG_FIRST  = 3'd1,
    REG_CENTER = 3'd2,
    REG_DIFFUSE = 3'd3,
    REG_STEP   = 3'd4
  } reg_idx_e;

  localparam q_t QMAX = 32'sh7fff_ffff;
  localparam q_t QMIN = 32'sh8000_0000;

  // Clamp a 40-bit value to Q8.24 range
  function automatic q_t sat40(input logic signed [39:0] x);
    q_t r;
    if (x > 40'sh00_7fff_ffff) r = QMAX;
    else if (x < -40'sh00_8000_0000) r = QMIN;
    else r = x[QW-1:0];
    return r;
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    logic signed [39:0] s;
    s = 40'(a) + 40'(b);
    return sat40(s);
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    logic signed [39:0] s;
    s = 40'(a) - 40'(b);
    return sat40(s);
  endfunction

  // Product, round half up, floor shift by 24, saturate
  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [63:0] p;
    logic signed [63:0] sh;
    p = 64'(a) * 64'(b) + 64'sd8388608;
    sh = p >>> 24;
    return sat40(sh[39:0]);
  endfunction

  function automatic q_t times3(input q_t a);
    logic signed [39:0] s;
    s = 40'(a) + 40'(a) + 40'(a);
    return sat40(s);
  endfunction

endpackage
`default_nettype wire

>>> hdl/p3su_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module p3su_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while disabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> hdl/periodic_3d_stencil_update.sv
// Periodic seven-point 3D stencil update, top level.
// Depends on p3su_pkg and p3su_ram.
//
// Items with action 0 load one grid point (u, v, u0, u1, u2) in raster
// order (k fastest, i slowest); items with action 1 request the updated u
// of the next raster point. One item is taken per cycle. A request reads
// its six v neighbours from six copies of the v memory and its centre
// fields from one field memory in the accept cycle, then passes the memory
// read register, stage registers 2 to 7 and the output register, which
// holds its result. A request sees every load accepted before it.
// Neighbours wrap on all three axes. When the output is held by
// out_stall_i the whole pipeline freezes and no input is taken.
`default_nettype none
module periodic_3d_stencil_update
  import p3su_pkg::*;
#(
  parameter int unsigned DIM_I = 16,
  parameter int unsigned DIM_J = 16,
  parameter int unsigned DIM_K = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        action_i,
  input  wire logic [31:0] u_val_i,
  input  wire logic [31:0] v_val_i,
  input  wire logic [31:0] u0_val_i,
  input  wire logic [31:0] u1_val_i,
  input  wire logic [31:0] u2_val_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      u_new_o,
  output logic             last_point_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned NPTS = DIM_I * DIM_J * DIM_K;
  localparam int unsigned AW = $clog2(NPTS);
  localparam int unsigned IW = $clog2(DIM_I);
  localparam int unsigned JW = $clog2(DIM_J);
  localparam int unsigned KW = $clog2(DIM_K);
  localparam logic [AW-1:0] LAST = AW'(NPTS - 1);
  localparam logic [AW-1:0] OFF_I = AW'(DIM_J * DIM_K);
  localparam logic [AW-1:0] WRAP_I = AW'((DIM_I - 1) * DIM_J * DIM_K);
  localparam logic [AW-1:0] OFF_J = AW'(DIM_K);
  localparam logic [AW-1:0] WRAP_J = AW'((DIM_J - 1) * DIM_K);
  localparam logic [AW-1:0] WRAP_K = AW'(DIM_K - 1);

  // ---------------- configuration ----------------
  q_t c0_q, c1_q, c2_q, c3_q, c4_q, c2x3_q;
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_q <= '0; c1_q <= '0; c2_q <= '0; c3_q <= '0; c4_q <= '0; c2x3_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ADVECT:  c0_q <= pwdata;
        REG_FIRST:   c1_q <= pwdata;
        REG_CENTER: begin
          c2_q   <= pwdata;
          c2x3_q <= times3(pwdata);
        end
        REG_DIFFUSE: c3_q <= pwdata;
        REG_STEP:    c4_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ADVECT:  prdata = c0_q;
      REG_FIRST:   prdata = c1_q;
      REG_CENTER:  prdata = c2_q;
      REG_DIFFUSE: prdata = c3_q;
      REG_STEP:    prdata = c4_q;
      default:     prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  logic adv, in_acc, ld_acc, rq_acc;
  assign adv        = ~(out_valid_o & out_stall_i);
  assign in_stall_o = ~adv;
  assign in_acc     = in_valid_i & adv;
  assign ld_acc     = in_acc & ~action_i;
  assign rq_acc     = in_acc & action_i;

  // ---------------- raster counters ----------------
  logic [AW-1:0] ld_idx_q, em_idx_q;
  logic [IW-1:0] em_i_q;
  logic [JW-1:0] em_j_q;
  logic [KW-1:0] em_k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_idx_q <= '0;
    end else if (ld_acc) begin
      ld_idx_q <= (ld_idx_q == LAST) ? '0 : ld_idx_q + AW'(1);
    end
  end

  // Advance the emit position, k fastest
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_idx_q <= '0; em_i_q <= '0; em_j_q <= '0; em_k_q <= '0;
    end else if (rq_acc) begin
      em_idx_q <= (em_idx_q == LAST) ? '0 : em_idx_q + AW'(1);
      if (em_k_q == KW'(DIM_K - 1)) begin
        em_k_q <= '0;
        if (em_j_q == JW'(DIM_J - 1)) begin
          em_j_q <= '0;
          em_i_q <= (em_i_q == IW'(DIM_I - 1)) ? '0 : em_i_q + IW'(1);
        end else begin
          em_j_q <= em_j_q + JW'(1);
        end
      end else begin
        em_k_q <= em_k_q + KW'(1);
      end
    end
  end

  // Neighbour addresses with periodic wrap
  logic [AW-1:0] a_im, a_ip, a_jm, a_jp, a_km, a_kp;
  always_comb begin
    a_im = (em_i_q == '0) ? em_idx_q + WRAP_I : em_idx_q - OFF_I;
    a_ip = (em_i_q == IW'(DIM_I - 1)) ? em_idx_q - WRAP_I : em_idx_q + OFF_I;
    a_jm = (em_j_q == '0) ? em_idx_q + WRAP_J : em_idx_q - OFF_J;
    a_jp = (em_j_q == JW'(DIM_J - 1)) ? em_idx_q - WRAP_J : em_idx_q + OFF_J;
    a_km = (em_k_q == '0) ? em_idx_q + WRAP_K : em_idx_q - AW'(1);
    a_kp = (em_k_q == KW'(DIM_K - 1)) ? em_idx_q - WRAP_K : em_idx_q + AW'(1);
  end

  // ---------------- memories ----------------
  logic [AW-1:0] rd_addr [6];
  q_t            vrd [6];
  logic [127:0]  frd;

  assign rd_addr[0] = a_im;
  assign rd_addr[1] = a_ip;
  assign rd_addr[2] = a_jm;
  assign rd_addr[3] = a_jp;
  assign rd_addr[4] = a_km;
  assign rd_addr[5] = a_kp;

  for (genvar g = 0; g < 6; g++) begin : g_vcopy
    p3su_ram #(.WIDTH(32), .DEPTH(NPTS)) u_vram (
      .clk_i   (clk_i),
      .we_i    (ld_acc),
      .waddr_i (ld_idx_q),
      .wdata_i (v_val_i),
      .re_i    (adv),
      .raddr_i (rd_addr[g]),
      .rdata_o (vrd[g])
    );
  end

  p3su_ram #(.WIDTH(128), .DEPTH(NPTS)) u_fram (
    .clk_i   (clk_i),
    .we_i    (ld_acc),
    .waddr_i (ld_idx_q),
    .wdata_i ({u_val_i, u0_val_i, u1_val_i, u2_val_i}),
    .re_i    (adv),
    .raddr_i (em_idx_q),
    .rdata_o (frd)
  );

  // ---------------- pipeline ----------------
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q, s6_vld_q;
  logic s1_last_q, s2_last_q, s3_last_q, s4_last_q, s5_last_q, s6_last_q;

  // Stage 2 registers: differences and operands
  q_t s2_di_q, s2_dj_q, s2_dk_q, s2_vim_q, s2_vip_q, s2_vjm_q, s2_vjp_q;
  q_t s2_vkm_q, s2_vkp_q, s2_u_q, s2_u0_q, s2_u1_q, s2_u2_q;
  // Stage 3: products
  q_t s3_m1_q, s3_a0_q, s3_a1_q, s3_a2_q, s3_cen_q, s3_u_q;
  q_t s3_vip_q, s3_vjm_q, s3_vjp_q, s3_vkm_q, s3_vkp_q;
  // Stage 4: sums
  q_t s4_nsum_q, s4_adv_q, s4_cen_q, s4_u_q;
  // Stage 5: scaled terms
  q_t s5_diff_q, s5_advm_q, s5_cen_q, s5_u_q;
  // Stage 6: inner term
  q_t s6_inner_q, s6_u_q;
  // Stage 7: step product
  q_t s7_prod_q, s7_u_q;
  logic s7_vld_q, s7_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0; s2_vld_q <= 1'b0; s3_vld_q <= 1'b0; s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0; s6_vld_q <= 1'b0; s7_vld_q <= 1'b0; out_valid_o <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= rq_acc;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
      s7_vld_q <= s6_vld_q;
      out_valid_o <= s7_vld_q;
    end
  end

  // Payload advances with the valid bits
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_last_q <= (em_idx_q == LAST);
      // differences
      s2_di_q  <= qsub(vrd[1], vrd[0]);
      s2_dj_q  <= qsub(vrd[3], vrd[2]);
      s2_dk_q  <= qsub(vrd[5], vrd[4]);
      s2_vim_q <= vrd[0]; s2_vip_q <= vrd[1]; s2_vjm_q <= vrd[2];
      s2_vjp_q <= vrd[3]; s2_vkm_q <= vrd[4]; s2_vkp_q <= vrd[5];
      s2_u_q   <= frd[127:96]; s2_u0_q <= frd[95:64];
      s2_u1_q  <= frd[63:32];  s2_u2_q <= frd[31:0];
      s2_last_q <= s1_last_q;
      // products
      s3_m1_q  <= qmul(c1_q, s2_vim_q);
      s3_a0_q  <= qmul(s2_di_q, s2_u0_q);
      s3_a1_q  <= qmul(s2_dj_q, s2_u1_q);
      s3_a2_q  <= qmul(s2_dk_q, s2_u2_q);
      s3_cen_q <= qmul(c2x3_q, s2_u_q);
      s3_u_q   <= s2_u_q;
      s3_vip_q <= s2_vip_q; s3_vjm_q <= s2_vjm_q; s3_vjp_q <= s2_vjp_q;
      s3_vkm_q <= s2_vkm_q; s3_vkp_q <= s2_vkp_q;
      s3_last_q <= s2_last_q;
      // neighbour and advection sums, left to right
      s4_nsum_q <= qadd(qadd(qadd(qadd(qadd(s3_m1_q, s3_vip_q), s3_vjm_q),
                                   s3_vjp_q), s3_vkm_q), s3_vkp_q);
      s4_adv_q  <= qadd(qadd(s3_a0_q, s3_a1_q), s3_a2_q);
      s4_cen_q  <= s3_cen_q;
      s4_u_q    <= s3_u_q;
      s4_last_q <= s3_last_q;
      // scale by diffusion and advection coefficients
      s5_diff_q <= qmul(c3_q, s4_nsum_q);
      s5_advm_q <= qmul(c0_q, s4_adv_q);
      s5_cen_q  <= s4_cen_q;
      s5_u_q    <= s4_u_q;
      s5_last_q <= s4_last_q;
      // combine
      s6_inner_q <= qsub(qsub(s5_diff_q, s5_cen_q), s5_advm_q);
      s6_u_q     <= s5_u_q;
      s6_last_q  <= s5_last_q;
      // time step
      s7_prod_q <= qmul(c4_q, s6_inner_q);
      s7_u_q    <= s6_u_q;
      s7_last_q <= s6_last_q;
      // output register
      u_new_o      <= qadd(s7_u_q, s7_prod_q);
      last_point_o <= s7_last_q;
    end
  end

  // ---------------- assertions ----------------
  a_freeze_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while pipeline frozen");

  a_req_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rq_acc |=> s1_vld_q)
    else $error("request lost at pipeline entry");

  a_load_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld_acc && ld_idx_q == LAST) |=> (ld_idx_q == '0))
    else $error("load index failed to wrap");

  a_emit_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rq_acc && em_idx_q == LAST) |=> (em_idx_q == '0 && em_k_q == '0 &&
                                      em_j_q == '0 && em_i_q == '0))
    else $error("emit position failed to wrap");

endmodule
`default_nettype wire

>>> test/periodic_3d_stencil_update_tb.sv
// Self-checking bench for the periodic 3D stencil update block.
// Depends on p3su_pkg and the block's RTL; predicts every updated point locally.
`default_nettype none
module periodic_3d_stencil_update_tb;
  import p3su_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NI = 16, NJ = 16, NK = 16;
  localparam int unsigned NPTS = NI * NJ * NK;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic        action;
    logic [31:0] u, v, u0, u1, u2;
  } beat_t;
  typedef struct packed {
    logic [31:0] u_new;
    logic        last;
  } point_t;

  logic clk, rst_n;
  logic in_valid, in_stall, action;
  logic [31:0] u_val, v_val, u0_val, u1_val, u2_val;
  logic out_valid, out_stall, last_point;
  logic [31:0] u_new;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;

  periodic_3d_stencil_update u_top (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .action_i(action), .u_val_i(u_val), .v_val_i(v_val), .u0_val_i(u0_val),
    .u1_val_i(u1_val), .u2_val_i(u2_val), .out_valid_o(out_valid),
    .out_stall_i(out_stall), .u_new_o(u_new), .last_point_o(last_point),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state
  longint v_grid [NPTS];
  longint f_grid [NPTS][4];
  int unsigned load_ptr, emit_ptr;
  longint coef [5];

  beat_t  pending_beats[$];
  point_t expected_points[$];
  int     errors;
  longint cycles;
  int     hold_off;
  bit     quiet_tail;

  function automatic longint clamp(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint fxmul(input longint a, input longint b);
    longint p;
    p = a * b + (64'sd1 << 23);
    return clamp(p >>> 24);
  endfunction

  function automatic longint sx(input logic [31:0] w);
    return longint'($signed(w));
  endfunction

  // Apply one beat to the predictor; queue a result on a request
  task automatic predict_beat(input beat_t b);
    int unsigned i, j, k, p;
    longint vim, vip, vjm, vjp, vkm, vkp, u, nsum, dif, cen, adv, inner, un;
    point_t r;
    if (!b.action) begin
      v_grid[load_ptr] = sx(b.v);
      f_grid[load_ptr][0] = sx(b.u);
      f_grid[load_ptr][1] = sx(b.u0);
      f_grid[load_ptr][2] = sx(b.u1);
      f_grid[load_ptr][3] = sx(b.u2);
      load_ptr = (load_ptr + 1) % NPTS;
    end else begin
      p = emit_ptr;
      i = p / (NJ * NK); j = (p / NK) % NJ; k = p % NK;
      vim = v_grid[(((i + NI - 1) % NI) * NJ + j) * NK + k];
      vip = v_grid[(((i + 1) % NI) * NJ + j) * NK + k];
      vjm = v_grid[(i * NJ + (j + NJ - 1) % NJ) * NK + k];
      vjp = v_grid[(i * NJ + (j + 1) % NJ) * NK + k];
      vkm = v_grid[(i * NJ + j) * NK + (k + NK - 1) % NK];
      vkp = v_grid[(i * NJ + j) * NK + (k + 1) % NK];
      u = f_grid[p][0];
      nsum = fxmul(coef[REG_FIRST], vim);
      nsum = clamp(nsum + vip); nsum = clamp(nsum + vjm); nsum = clamp(nsum + vjp);
      nsum = clamp(nsum + vkm); nsum = clamp(nsum + vkp);
      dif = fxmul(coef[REG_DIFFUSE], nsum);
      cen = fxmul(clamp(3 * coef[REG_CENTER]), u);
      adv = fxmul(clamp(vip - vim), f_grid[p][1]);
      adv = clamp(adv + fxmul(clamp(vjp - vjm), f_grid[p][2]));
      adv = clamp(adv + fxmul(clamp(vkp - vkm), f_grid[p][3]));
      adv = fxmul(coef[REG_ADVECT], adv);
      inner = clamp(clamp(dif - cen) - adv);
      un = clamp(u + fxmul(coef[REG_STEP], inner));
      r.u_new = un[31:0];
      r.last = (p == NPTS - 1);
      expected_points.push_back(r);
      emit_ptr = (p + 1) % NPTS;
    end
  endtask

  function automatic logic [31:0] rnd_q();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic beat_t mk_beat(input logic act);
    beat_t b;
    b.action = act; b.u = rnd_q(); b.v = rnd_q();
    b.u0 = rnd_q(); b.u1 = rnd_q(); b.u2 = rnd_q();
    return b;
  endfunction

  // Clock and cycle watchdog
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Driver: present queued beats, idle in random bursts
  int drv_gap;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0; drv_gap <= 0;
    end else if (!(in_valid && in_stall)) begin
      // Drop the beat taken at this edge; the next one is then at the front
      if (in_valid) void'(pending_beats.pop_front());
      if (drv_gap > 0) begin
        in_valid <= 1'b0; drv_gap <= drv_gap - 1;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        in_valid <= 1'b0; drv_gap <= $urandom_range(0, 4);
      end else if (pending_beats.size() > 0) begin
        beat_t b;
        b = pending_beats[0];
        in_valid <= 1'b1; action <= b.action;
        u_val <= b.u; v_val <= b.v; u0_val <= b.u0; u1_val <= b.u1; u2_val <= b.u2;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Prediction runs on each accepted beat
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      predict_beat(beat_t'{action, u_val, v_val, u0_val, u1_val, u2_val});
  end

  // Receiver stall: random bursts plus a long hold-off on request
  int stall_left;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0; stall_left <= 0;
    end else if (hold_off > 0) begin
      out_stall <= 1'b1; hold_off <= hold_off - 1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1; stall_left <= stall_left - 1;
    end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1; stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result u_new=%h last=%b", $realtime, u_new, last_point);
        errors++;
      end else begin
        point_t e;
        e = expected_points.pop_front();
        if (e.u_new !== u_new) begin
          $display("%0t: u_new expected %h actual %h", $realtime, e.u_new, u_new);
          errors++;
        end
        if (e.last !== last_point) begin
          $display("%0t: last_point expected %b actual %b", $realtime, e.last, last_point);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 5'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    coef[idx] = sx(val);
  endtask

  // Idle, then let the pipeline drain
  task automatic drain();
    wait (pending_beats.size() == 0 && !in_valid);
    wait (expected_points.size() == 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_coefs(input logic [31:0] c0, c1, c2, c3, c4);
    write_reg(REG_ADVECT, c0); write_reg(REG_FIRST, c1); write_reg(REG_CENTER, c2);
    write_reg(REG_DIFFUSE, c3); write_reg(REG_STEP, c4);
  endtask

  // Load a full grid then request every point, with some mixing
  task automatic queue_pass(input int mix);
    for (int n = 0; n < mix; n++) pending_beats.push_back(mk_beat(1'b0));
    for (int n = 0; n < NPTS - mix; n++) begin
      pending_beats.push_back(mk_beat(1'b0));
      pending_beats.push_back(mk_beat(1'b1));
    end
    for (int n = 0; n < mix; n++) pending_beats.push_back(mk_beat(1'b1));
  endtask

  initial begin
    beat_t b;
    errors = 0; cycles = 0; hold_off = 0; quiet_tail = 0;
    load_ptr = 0; emit_ptr = 0;
    foreach (coef[n]) coef[n] = 0;
    foreach (v_grid[n]) v_grid[n] = 0;
    rst_n = 0; in_valid = 0; out_stall = 0; action = 0;
    u_val = 0; v_val = 0; u0_val = 0; u1_val = 0; u2_val = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme coefficients, full grid of extreme values
    set_coefs(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    for (int n = 0; n < NPTS; n++) begin
      b.action = 1'b0;
      b.u = (n % 2) ? 32'h7fff_ffff : 32'h8000_0000;
      b.v = (n % 3) ? 32'h8000_0000 : 32'h7fff_ffff;
      b.u0 = 32'hffff_ffff; b.u1 = 32'h0; b.u2 = 32'h7fff_ffff;
      pending_beats.push_back(b);
    end
    for (int n = 0; n < 20; n++) pending_beats.push_back(mk_beat(1'b1));
    drain();

    // Moderate coefficients; finish the grid, including the last point wrap
    set_coefs(32'h0010_0000, 32'h0100_0000, 32'hff80_0000, 32'h0040_0000, 32'h0080_0000);
    for (int n = 20; n < NPTS; n++) pending_beats.push_back(mk_beat(1'b1));
    // Reload while requesting; long receiver hold-off fills the pipeline
    for (int n = 0; n < 300; n++) pending_beats.push_back(mk_beat(1'b0));
    hold_off = 200;
    for (int n = 0; n < 300; n++) pending_beats.push_back(mk_beat(1'b1));
    drain();

    // Random coefficient settings, mixed loads and requests
    for (int ph = 0; ph < 3; ph++) begin
      set_coefs($urandom, $urandom, $urandom, $urandom, $urandom);
      for (int n = 0; n < 350; n++) pending_beats.push_back(mk_beat($urandom_range(0, 1)));
      if (ph == 2) quiet_tail = 1;
      drain();
    end
    set_coefs(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    queue_pass(0);
    pending_beats = pending_beats[0:99];
    drain();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> periodic_3d_stencil_update.f
hdl/p3su_pkg.sv
hdl/p3su_ram.sv
hdl/periodic_3d_stencil_update.sv
test/periodic_3d_stencil_update_tb.sv
